### hw/rtl/arxsc_pkg.sv
// ----------------------------------------------------------------------------
// arxsc_pkg
// Shared types, constants and helpers for the ARX keystream block cipher.
// ----------------------------------------------------------------------------
package arxsc_pkg;

    // default number of rounds per block
    localparam int unsigned ROUNDS_DEFAULT = 16;

    // configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD_0   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD_1   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD_2   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY_WORD_3   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_NONCE_WORD_0 = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_NONCE_WORD_1 = 3'd5;

    // fixed state constants, cells (0,3) (1,0) (2,1) (3,2)
    localparam logic [31:0] INIT_CONST_0 = 32'hcaf26468;
    localparam logic [31:0] INIT_CONST_1 = 32'hce9637c2;
    localparam logic [31:0] INIT_CONST_2 = 32'hb052d5d9;
    localparam logic [31:0] INIT_CONST_3 = 32'hda2116df;

    // input beat
    typedef struct packed {
        logic [63:0] data_word_0;
        logic [63:0] data_word_1;
        logic [63:0] data_word_2;
        logic [63:0] data_word_3;
        logic        restart;
        logic [5:0]  byte_count;
    } t_in;

    // output beat
    typedef struct packed {
        logic [63:0] out_word_0;
        logic [63:0] out_word_1;
        logic [63:0] out_word_2;
        logic [63:0] out_word_3;
    } t_out;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_ctrl_state;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;   // take input beat, reload state on restart
        logic       step;      // apply one quarter of a round
        logic [1:0] phase;     // which quarter
        logic       emit;      // register the result beat
    } t_dp_cmd;

    // rotate left by a constant amount
    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

### hw/rtl/arxsc_ctrl.sv
// ----------------------------------------------------------------------------
// arxsc_ctrl
// Sequencer: accepts a beat, steps the datapath through the rounds one
// quarter round per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module arxsc_ctrl #(
    parameter int unsigned ROUNDS = arxsc_pkg::ROUNDS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output arxsc_pkg::t_dp_cmd o_cmd
);

    localparam int unsigned STEPS = 4 * ROUNDS;
    localparam int unsigned CW    = (STEPS > 4) ? $clog2(STEPS) : 2;
    localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

    arxsc_pkg::t_ctrl_state r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;

    // state, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arxsc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.phase = r_cnt[1:0];
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            arxsc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = arxsc_pkg::ST_RUN;
                end
            end
            arxsc_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = arxsc_pkg::ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            arxsc_pkg::ST_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = arxsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arxsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/arxsc_datapath.sv
// ----------------------------------------------------------------------------
// arxsc_datapath
// Key and nonce registers, the 4x4 cipher state with its quarter-round
// logic, the captured input beat and the output register.
// ----------------------------------------------------------------------------
module arxsc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [arxsc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [63:0]                  i_cfg_wdata,
    input  arxsc_pkg::t_in               i_in_data,
    input  arxsc_pkg::t_dp_cmd           i_cmd,
    output arxsc_pkg::t_out              o_out_data
);

    logic [63:0]     r_key_0, r_key_1, r_key_2, r_key_3;
    logic [63:0]     r_nonce_0, r_nonce_1;
    logic [31:0]     r_s [16];
    logic [31:0]     n_s [16];
    logic [31:0]     v [16];
    arxsc_pkg::t_in  r_in;
    arxsc_pkg::t_out r_out, n_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0   <= '0;
            r_key_1   <= '0;
            r_key_2   <= '0;
            r_key_3   <= '0;
            r_nonce_0 <= '0;
            r_nonce_1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                arxsc_pkg::CFG_KEY_WORD_0:   r_key_0   <= i_cfg_wdata;
                arxsc_pkg::CFG_KEY_WORD_1:   r_key_1   <= i_cfg_wdata;
                arxsc_pkg::CFG_KEY_WORD_2:   r_key_2   <= i_cfg_wdata;
                arxsc_pkg::CFG_KEY_WORD_3:   r_key_3   <= i_cfg_wdata;
                arxsc_pkg::CFG_NONCE_WORD_0: r_nonce_0 <= i_cfg_wdata;
                arxsc_pkg::CFG_NONCE_WORD_1: r_nonce_1 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // quarter round on the current state; the last quarter also shifts rows
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            v[i] = r_s[i];
        end
        case (i_cmd.phase)
            2'd0: begin
                v[5]  = v[5] + v[14];  v[10] = arxsc_pkg::rotl(v[10] ^ v[5], 7);
                v[15] = v[15] + v[3];  v[0]  = arxsc_pkg::rotl(v[0] ^ v[15], 13);
                v[8]  = v[8] + v[4];   v[13] = arxsc_pkg::rotl(v[13] ^ v[8], 29);
                v[2]  = v[2] + v[9];   v[7]  = arxsc_pkg::rotl(v[7] ^ v[2], 31);
            end
            2'd1: begin
                v[9]  = v[9] + v[8];   v[14] = arxsc_pkg::rotl(v[14] ^ v[9], 7);
                v[3]  = v[3] ^ v[13];  v[4]  = arxsc_pkg::rotl(v[4] + v[3], 13);
                v[12] = v[12] + v[2];  v[1]  = arxsc_pkg::rotl(v[1] ^ v[12], 29);
                v[6]  = v[6] ^ v[7];   v[11] = arxsc_pkg::rotl(v[11] + v[6], 31);
            end
            2'd2: begin
                v[13] = v[13] + v[1];  v[2]  = arxsc_pkg::rotl(v[2] ^ v[13], 7);
                v[7]  = v[7] + v[6];   v[8]  = arxsc_pkg::rotl(v[8] ^ v[7], 13);
                v[0]  = v[0] + v[11];  v[5]  = arxsc_pkg::rotl(v[5] ^ v[0], 29);
                v[10] = v[10] + v[12]; v[15] = arxsc_pkg::rotl(v[15] ^ v[10], 31);
            end
            default: begin
                v[9]  = v[9] + v[5];   v[14] = arxsc_pkg::rotl(v[14] ^ v[9], 7);
                v[3]  = v[3] ^ v[10];  v[4]  = arxsc_pkg::rotl(v[4] + v[3], 13);
                v[12] = v[12] + v[15]; v[1]  = arxsc_pkg::rotl(v[1] ^ v[12], 29);
                v[6]  = v[6] ^ v[0];   v[11] = arxsc_pkg::rotl(v[11] + v[6], 31);
            end
        endcase
        // rows 1..3 move up, old row 0 rotated by one word becomes row 3
        if (i_cmd.phase == 2'd3) begin
            for (int i = 0; i < 12; i++) begin
                n_s[i] = v[i + 4];
            end
            n_s[12] = v[1];
            n_s[13] = v[2];
            n_s[14] = v[3];
            n_s[15] = v[0];
        end else begin
            for (int i = 0; i < 16; i++) begin
                n_s[i] = v[i];
            end
        end
    end

    // cipher state: reload on restart, advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_s[i] <= '0;
            end
        end else if (i_cmd.capture && i_in_data.restart) begin
            r_s[0]  <= r_key_0[63:32];   r_s[5]  <= r_key_0[31:0];
            r_s[10] <= r_key_1[63:32];   r_s[15] <= r_key_1[31:0];
            r_s[1]  <= r_key_2[63:32];   r_s[6]  <= r_key_2[31:0];
            r_s[11] <= r_key_3[63:32];   r_s[12] <= r_key_3[31:0];
            r_s[2]  <= r_nonce_0[63:32]; r_s[7]  <= r_nonce_0[31:0];
            r_s[8]  <= r_nonce_1[63:32]; r_s[13] <= r_nonce_1[31:0];
            r_s[3]  <= arxsc_pkg::INIT_CONST_0;
            r_s[4]  <= arxsc_pkg::INIT_CONST_1;
            r_s[9]  <= arxsc_pkg::INIT_CONST_2;
            r_s[14] <= arxsc_pkg::INIT_CONST_3;
        end else if (i_cmd.step) begin
            for (int i = 0; i < 16; i++) begin
                r_s[i] <= n_s[i];
            end
        end
    end

    // keystream xor and byte masking
    always_comb begin
        logic [63:0] ks [4];
        logic [63:0] dw [4];
        logic [63:0] ow [4];
        dw[0] = r_in.data_word_0;
        dw[1] = r_in.data_word_1;
        dw[2] = r_in.data_word_2;
        dw[3] = r_in.data_word_3;
        for (int w = 0; w < 4; w++) begin
            ks[w] = {r_s[2*w] ^ r_s[2*w+8], r_s[2*w+1] ^ r_s[2*w+9]};
            ow[w] = dw[w] ^ ks[w];
            for (int j = 0; j < 8; j++) begin
                if (6'(8*w + j) >= r_in.byte_count) begin
                    ow[w][63-8*j -: 8] = 8'h00;
                end
            end
        end
        n_out.out_word_0 = ow[0];
        n_out.out_word_1 = ow[1];
        n_out.out_word_2 = ow[2];
        n_out.out_word_3 = ow[3];
    end

    // input capture and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

### hw/rtl/arx_stream_cipher_block_xor.sv
// ----------------------------------------------------------------------------
// arx_stream_cipher_block_xor
// An input beat is captured, stepped through all rounds with one quarter round
// applied per cycle, then registered as its output beat.
// A new beat is accepted only once the previous result is in the output register.
// The output register lets a new beat enter while a result waits.
// Reset (synchronous, active low) clears keys, nonce and cipher state to zero.
// ----------------------------------------------------------------------------
module arx_stream_cipher_block_xor #(
    parameter int unsigned ROUNDS = arxsc_pkg::ROUNDS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [arxsc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [63:0]                  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  arxsc_pkg::t_in               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output arxsc_pkg::t_out              o_out_data
);

    arxsc_pkg::t_dp_cmd cmd;

    arxsc_ctrl #(
        .ROUNDS(ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    arxsc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

### hw/rtl/arxsc_checker.sv
// ----------------------------------------------------------------------------
// arxsc_checker
// Port-level checks on beat ordering and timing, bound to the top level.
// ----------------------------------------------------------------------------
module arxsc_checker #(
    parameter int unsigned ROUNDS = arxsc_pkg::ROUNDS_DEFAULT
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input arxsc_pkg::t_out o_out_data
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // busy right after an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again before rounds ran");

    // still busy through the last round
    a_busy_through_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##(4*ROUNDS) !o_in_ready)
        else $error("block left the round sequence early");

    // an output beat only goes away when taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("output beat dropped without a handshake");

endmodule

bind arx_stream_cipher_block_xor arxsc_checker #(
    .ROUNDS(ROUNDS)
) u_arxsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### bench/arx_stream_cipher_block_xor_check.sv
// ----------------------------------------------------------------------------
// arx_stream_cipher_block_xor_check
// Watches the config port and both streams of the ARX block cipher, keeps its
// own copy of key, nonce and cipher state, predicts each output beat and
// compares it word by word with what the block delivers.
// ----------------------------------------------------------------------------
module arx_stream_cipher_block_xor_check #(
    parameter int unsigned ROUNDS = arxsc_pkg::ROUNDS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [arxsc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [63:0]                  i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  arxsc_pkg::t_in               i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  arxsc_pkg::t_out              i_out_data,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0]     key_reg [4];
    logic [63:0]     nonce_reg [2];
    // cipher state, cell index = row*4 + col
    logic [31:0]     st [16];
    arxsc_pkg::t_out cipher_q [$];
    int              error_count = 0;
    int              beat_count = 0;
    int              pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_checked = beat_count;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // advance the state by one block and XOR the keystream over the data
    task automatic encrypt_block(input arxsc_pkg::t_in b, output arxsc_pkg::t_out r);
        logic [31:0] t [16];
        logic [63:0] din [4];
        logic [63:0] dout [4];
        logic [63:0] ks;
        logic [63:0] mask;
        int          count;
        int          n;

        din[0] = b.data_word_0;
        din[1] = b.data_word_1;
        din[2] = b.data_word_2;
        din[3] = b.data_word_3;
        count = int'(b.byte_count);
        if (count > 32) count = 32;

        // reload: key on the diagonals, nonce and constants on the rest
        if (b.restart) begin
            st[0]  = key_reg[0][63:32];   st[5]  = key_reg[0][31:0];
            st[10] = key_reg[1][63:32];   st[15] = key_reg[1][31:0];
            st[1]  = key_reg[2][63:32];   st[6]  = key_reg[2][31:0];
            st[11] = key_reg[3][63:32];   st[12] = key_reg[3][31:0];
            st[2]  = nonce_reg[0][63:32]; st[7]  = nonce_reg[0][31:0];
            st[8]  = nonce_reg[1][63:32]; st[13] = nonce_reg[1][31:0];
            st[3]  = arxsc_pkg::INIT_CONST_0;
            st[4]  = arxsc_pkg::INIT_CONST_1;
            st[9]  = arxsc_pkg::INIT_CONST_2;
            st[14] = arxsc_pkg::INIT_CONST_3;
        end

        repeat (ROUNDS) begin
            st[5]  += st[14]; st[10] = rol32(st[10] ^ st[5], 7);
            st[15] += st[3];  st[0]  = rol32(st[0] ^ st[15], 13);
            st[8]  += st[4];  st[13] = rol32(st[13] ^ st[8], 29);
            st[2]  += st[9];  st[7]  = rol32(st[7] ^ st[2], 31);

            st[9]  += st[8];  st[14] = rol32(st[14] ^ st[9], 7);
            st[3]  ^= st[13]; st[4]  = rol32(st[4] + st[3], 13);
            st[12] += st[2];  st[1]  = rol32(st[1] ^ st[12], 29);
            st[6]  ^= st[7];  st[11] = rol32(st[11] + st[6], 31);

            st[13] += st[1];  st[2]  = rol32(st[2] ^ st[13], 7);
            st[7]  += st[6];  st[8]  = rol32(st[8] ^ st[7], 13);
            st[0]  += st[11]; st[5]  = rol32(st[5] ^ st[0], 29);
            st[10] += st[12]; st[15] = rol32(st[15] ^ st[10], 31);

            st[9]  += st[5];  st[14] = rol32(st[14] ^ st[9], 7);
            st[3]  ^= st[10]; st[4]  = rol32(st[4] + st[3], 13);
            st[12] += st[15]; st[1]  = rol32(st[1] ^ st[12], 29);
            st[6]  ^= st[0];  st[11] = rol32(st[11] + st[6], 31);

            // rows move up; old row 0 rotated by one word becomes row 3
            t = st;
            for (int i = 0; i < 12; i++) st[i] = t[i + 4];
            st[12] = t[1];
            st[13] = t[2];
            st[14] = t[3];
            st[15] = t[0];
        end

        // keystream = row0^row2, row1^row3; bytes past the count are cleared
        for (int w = 0; w < 4; w++) begin
            ks = {st[2*w] ^ st[2*w+8], st[2*w+1] ^ st[2*w+9]};
            n = count - 8*w;
            if (n < 0) n = 0;
            if (n > 8) n = 8;
            mask = (n == 0) ? 64'd0 : (~64'd0 << (64 - 8*n));
            dout[w] = (din[w] ^ ks) & mask;
        end
        r.out_word_0 = dout[0];
        r.out_word_1 = dout[1];
        r.out_word_2 = dout[2];
        r.out_word_3 = dout[3];
    endtask

    // config snoop, prediction on input beats, compare on output beats
    always @(posedge i_clk) begin : monitor
        arxsc_pkg::t_out predicted;
        arxsc_pkg::t_out oldest;
        logic [63:0]     got [4];
        logic [63:0]     want [4];

        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_reg[i] = '0;
            for (int i = 0; i < 2; i++) nonce_reg[i] = '0;
            for (int i = 0; i < 16; i++) st[i] = '0;
            cipher_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    arxsc_pkg::CFG_KEY_WORD_0:   key_reg[0] = i_cfg_wdata;
                    arxsc_pkg::CFG_KEY_WORD_1:   key_reg[1] = i_cfg_wdata;
                    arxsc_pkg::CFG_KEY_WORD_2:   key_reg[2] = i_cfg_wdata;
                    arxsc_pkg::CFG_KEY_WORD_3:   key_reg[3] = i_cfg_wdata;
                    arxsc_pkg::CFG_NONCE_WORD_0: nonce_reg[0] = i_cfg_wdata;
                    arxsc_pkg::CFG_NONCE_WORD_1: nonce_reg[1] = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: output beat with nothing expected: %h",
                                 $realtime, i_out_data);
                end else begin
                    oldest = cipher_q.pop_front();
                    got[0]  = i_out_data.out_word_0;  want[0] = oldest.out_word_0;
                    got[1]  = i_out_data.out_word_1;  want[1] = oldest.out_word_1;
                    got[2]  = i_out_data.out_word_2;  want[2] = oldest.out_word_2;
                    got[3]  = i_out_data.out_word_3;  want[3] = oldest.out_word_3;
                    for (int w = 0; w < 4; w++) begin
                        if (got[w] !== want[w]) begin
                            error_count++;
                            if (error_count <= 10)
                                $display("%0t: block %0d out_word_%0d expected %h got %h",
                                         $realtime, beat_count, w, want[w], got[w]);
                        end
                    end
                    beat_count++;
                end
            end

            if (i_in_valid && i_in_ready) begin
                encrypt_block(i_in_data, predicted);
                cipher_q.push_back(predicted);
            end
        end
        pending_count = cipher_q.size();
    end

endmodule

### bench/arx_stream_cipher_block_xor_test.sv
// ----------------------------------------------------------------------------
// arx_stream_cipher_block_xor_test
// Drives key/nonce settings and 32-byte blocks into the ARX block cipher with
// random gaps and output stalls; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module arx_stream_cipher_block_xor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY      = 4 * arxsc_pkg::ROUNDS_DEFAULT + 2;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned PHASE_BLOCKS = 80;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [arxsc_pkg::CFG_AW-1:0] cfg_addr;
    logic [63:0]                  cfg_wdata;
    logic                         in_valid;
    logic                         in_ready;
    arxsc_pkg::t_in               in_beat;
    logic                         out_valid;
    logic                         out_ready;
    arxsc_pkg::t_out              out_beat;

    int errors;
    int pending;
    int checked;
    int cycle_count = 0;
    int blocks_sent = 0;
    int restarts_sent = 0;
    int short_sent = 0;
    int long_sent = 0;
    int key_sets = 0;

    arx_stream_cipher_block_xor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    arx_stream_cipher_block_xor_check u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout at cycle %0d with %0d beats outstanding", cycle_count, pending);
        $display("[arx_stream_cipher_block_xor] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // byte count: mostly full blocks, some short, empty and over-long ones
    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return 6'd32;
        if (r < 90) return 6'($urandom_range(1, 31));
        if (r < 95) return 6'd0;
        return 6'($urandom_range(33, 63));
    endfunction

    // register value for a phase: zeros, ones, or random with some extremes
    function automatic logic [63:0] pick_reg(input int phase);
        int r;
        if (phase == 0) return '0;
        if (phase == 1) return '1;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return rand64();
    endfunction

    function automatic arxsc_pkg::t_in make_block(input logic restart, input logic [5:0] bc,
                                                  input logic [63:0] fill,
                                                  input logic use_fill);
        arxsc_pkg::t_in b;
        b.data_word_0 = use_fill ? fill : rand64();
        b.data_word_1 = use_fill ? fill : rand64();
        b.data_word_2 = use_fill ? fill : rand64();
        b.data_word_3 = use_fill ? fill : rand64();
        b.restart     = restart;
        b.byte_count  = bc;
        return b;
    endfunction

    task automatic write_reg(input logic [arxsc_pkg::CFG_AW-1:0] addr,
                             input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] n0, input logic [63:0] n1);
        write_reg(arxsc_pkg::CFG_KEY_WORD_0, k0);
        write_reg(arxsc_pkg::CFG_KEY_WORD_1, k1);
        write_reg(arxsc_pkg::CFG_KEY_WORD_2, k2);
        write_reg(arxsc_pkg::CFG_KEY_WORD_3, k3);
        write_reg(arxsc_pkg::CFG_NONCE_WORD_0, n0);
        write_reg(arxsc_pkg::CFG_NONCE_WORD_1, n1);
        key_sets++;
    endtask

    // hold the beat until the block takes it
    task automatic send_block(input arxsc_pkg::t_in b);
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        blocks_sent++;
        if (b.restart) restarts_sent++;
        if (b.byte_count < 6'd32) short_sent++;
        if (b.byte_count > 6'd32) long_sent++;
    endtask

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // stop sending until every expected beat has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // output side back-pressure: bursts of ready, then stalls
    initial begin
        out_ready = 1'b0;
        forever begin
            repeat ($urandom_range(1, 40)) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                repeat (gap_len()) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic dense;
        logic restart;
        int   counts [10];

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_beat   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // registers still at reset: state runs on from zero, then reload zero key
        send_block(make_block(1'b0, 6'd32, '0, 1'b1));
        send_block(make_block(1'b0, 6'd32, '1, 1'b1));
        send_block(make_block(1'b1, 6'd32, '0, 1'b1));
        drain();

        // all-ones key and nonce; sweep byte counts over byte and word edges
        set_keys('1, '1, '1, '1, '1, '1);
        send_block(make_block(1'b1, 6'd32, '1, 1'b1));
        send_block(make_block(1'b0, 6'd0, '1, 1'b1));
        counts = '{1, 7, 8, 9, 16, 24, 31, 33, 40, 63};
        foreach (counts[i]) send_block(make_block(1'b0, 6'(counts[i]), '1, 1'b1));
        send_block(make_block(1'b1, 6'd32, 64'haaaa_aaaa_aaaa_aaaa, 1'b1));
        send_block(make_block(1'b0, 6'd32, 64'h5555_5555_5555_5555, 1'b1));
        send_block(make_block(1'b0, 6'd17, '0, 1'b0));

        // random phases, each under its own key and nonce
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_keys(pick_reg(p), pick_reg(p), pick_reg(p), pick_reg(p),
                     pick_reg(p), pick_reg(p));
            dense = 1'b0;
            for (int i = 0; i < PHASE_BLOCKS; i++) begin
                if (i == PHASE_BLOCKS / 2) drain();
                // phase 3 keeps running on the old state before its first reload
                restart = (i == 0) ? (p != 3) : ($urandom_range(0, 9) == 0);
                send_block(make_block(restart, pick_count(), '0, 1'b0));
                if (!dense) idle(gap_len());
                if (i % 16 == 15) dense = ($urandom_range(0, 2) == 0);
            end
        end

        // wait out the tail
        drain();
        repeat (LATENCY) @(negedge clk);

        $display("sent %0d blocks: %0d reloads, %0d short or empty, %0d over-long counts",
                 blocks_sent, restarts_sent, short_sent, long_sent);
        $display("%0d key/nonce settings, %0d result beats checked", key_sets, checked);
        if (errors == 0 && pending == 0) begin
            $display("[arx_stream_cipher_block_xor] OK");
        end else begin
            $display("[arx_stream_cipher_block_xor] ERROR");
        end
        $finish;
    end

endmodule
